[sv/pstsc_pkg.sv]
// ----------------------------------------------------------------------------
// pstsc_pkg: shared types and constants of the token scanner
// Token codes, scan modes, keyword table and the token group carried from the
// scanner front to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pstsc_pkg;

  localparam int unsigned TOKEN_W = 6;
  localparam int unsigned LINE_OUT_W = 16;
  localparam int unsigned START_W = 32;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned NRES = 3;
  localparam int unsigned NRES_W = 2;
  localparam int unsigned KW_N = 15;
  localparam int unsigned KW_BUF = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Token codes (keywords are their table index)
  localparam logic [TOKEN_W-1:0] TOK_IDENT   = 6'd15;
  localparam logic [TOKEN_W-1:0] TOK_ICONST  = 6'd16;
  localparam logic [TOKEN_W-1:0] TOK_RCONST  = 6'd17;
  localparam logic [TOKEN_W-1:0] TOK_SCONST  = 6'd18;
  localparam logic [TOKEN_W-1:0] TOK_PLUS    = 6'd19;
  localparam logic [TOKEN_W-1:0] TOK_MINUS   = 6'd20;
  localparam logic [TOKEN_W-1:0] TOK_MULT    = 6'd21;
  localparam logic [TOKEN_W-1:0] TOK_DIV     = 6'd22;
  localparam logic [TOKEN_W-1:0] TOK_ASSOP   = 6'd23;
  localparam logic [TOKEN_W-1:0] TOK_EQUAL   = 6'd24;
  localparam logic [TOKEN_W-1:0] TOK_GTHAN   = 6'd25;
  localparam logic [TOKEN_W-1:0] TOK_LTHAN   = 6'd26;
  localparam logic [TOKEN_W-1:0] TOK_COMMA   = 6'd27;
  localparam logic [TOKEN_W-1:0] TOK_LPAREN  = 6'd28;
  localparam logic [TOKEN_W-1:0] TOK_RPAREN  = 6'd29;
  localparam logic [TOKEN_W-1:0] TOK_COLON   = 6'd30;
  localparam logic [TOKEN_W-1:0] TOK_SEMICOL = 6'd31;
  localparam logic [TOKEN_W-1:0] TOK_ERR     = 6'd32;
  localparam logic [TOKEN_W-1:0] TOK_DONE    = 6'd33;

  typedef enum logic [5:0] {
    M_START   = 6'b000001,
    M_ID      = 6'b000010,
    M_STR     = 6'b000100,
    M_INT     = 6'b001000,
    M_REAL    = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_e;

  // Keywords, left aligned, zero padded
  localparam logic [55:0] KW_TEXT [KW_N] = '{
    "PROGRAM", "WRITELN", "INTEGER", {"END", 32'd0}, {"REAL", 24'd0},
    {"STRING", 8'd0}, {"FOR", 32'd0}, {"VAR", 32'd0}, {"ELSE", 24'd0},
    {"IF", 40'd0}, {"BEGIN", 16'd0}, {"THEN", 24'd0}, {"DO", 40'd0},
    {"TO", 40'd0}, {"DOWNTO", 8'd0}
  };
  localparam logic [2:0] KW_LEN [KW_N] = '{
    3'd7, 3'd7, 3'd7, 3'd3, 3'd4, 3'd6, 3'd3, 3'd3, 3'd4, 3'd2, 3'd5, 3'd4,
    3'd2, 3'd2, 3'd6
  };

  typedef struct packed {
    logic [TOKEN_W-1:0]    token;
    logic [LINE_OUT_W-1:0] line;
    logic [START_W-1:0]    lexeme_start;
    logic [LEN_W-1:0]      lexeme_length;
    logic                  unclosed_comment;
  } tok_t;

  // Tokens caused by one input character
  typedef struct packed {
    logic [NRES_W-1:0]       n;
    tok_t [NRES-1:0]         toks;
  } bundle_t;

  // Match an upper-cased identifier against the keyword table
  function automatic logic [TOKEN_W-1:0] kw_lookup(input logic [KW_BUF-1:0][7:0] kb,
                                                   input logic [LEN_W-1:0] cnt);
    logic [TOKEN_W-1:0] tok;
    logic               hit;
    tok = TOK_IDENT;
    for (int k = KW_N - 1; k >= 0; k--) begin
      hit = (cnt == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_BUF; i++) begin
        if (i < int'(KW_LEN[k]) && kb[i] != KW_TEXT[k][55-8*i -: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        tok = TOKEN_W'(k);
      end
    end
    return tok;
  endfunction

endpackage

`default_nettype wire

[sv/pstsc_front.sv]
// ----------------------------------------------------------------------------
// pstsc_front: character scanner
// Holds one character for lookahead, tracks scan mode, line and position, and
// turns each accepted character into a group of up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module pstsc_front
  import pstsc_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [LINE_OUT_W-1:0] cfg_wdata_i,
  output bundle_t                    bundle_o,
  output logic                       bundle_valid_o
);

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? 8'(c - 8'd32) : c;
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : LEN_W'(v + 1'b1);
  endfunction

  function automatic logic [TOKEN_W-1:0] sym_token(input logic [7:0] c);
    logic [TOKEN_W-1:0] t;
    unique case (c)
      "+":     t = TOK_PLUS;
      "-":     t = TOK_MINUS;
      "*":     t = TOK_MULT;
      "/":     t = TOK_DIV;
      "=":     t = TOK_EQUAL;
      ">":     t = TOK_GTHAN;
      "<":     t = TOK_LTHAN;
      ",":     t = TOK_COMMA;
      ")":     t = TOK_RPAREN;
      ";":     t = TOK_SEMICOL;
      default: t = TOK_ERR;
    endcase
    return t;
  endfunction

  // Append one token to the group, dropping any beyond the group size
  function automatic bundle_t put(input bundle_t b, input logic [TOKEN_W-1:0] tok,
                                  input logic [LINE_OUT_W-1:0] ln,
                                  input logic [START_W-1:0] st,
                                  input logic [LEN_W-1:0] len, input logic uc);
    bundle_t r;
    r = b;
    if (r.n < NRES_W'(NRES)) begin
      r.toks[r.n].token = tok;
      r.toks[r.n].line = ln;
      r.toks[r.n].lexeme_start = st;
      r.toks[r.n].lexeme_length = len;
      r.toks[r.n].unclosed_comment = uc;
      r.n = NRES_W'(r.n + 1'b1);
    end
    return r;
  endfunction

  mode_e                        mode_q, mode_d;
  logic                         dec_q, dec_d;
  logic [7:0]                   held_q, held_d;
  logic                         hvalid_q, hvalid_d;
  logic [LINE_WIDTH-1:0]        line_q, line_d;
  logic [LINE_OUT_W-1:0]        start_line_q;
  logic [POSITION_WIDTH-1:0]    pos_q, pos_d;
  logic [POSITION_WIDTH-1:0]    tbeg_q, tbeg_d;
  logic [LEN_W-1:0]             tcnt_q, tcnt_d;
  logic [KW_BUF-1:0][7:0]       kb_q, kb_d;

  logic [POSITION_WIDTH-1:0]    hpos;
  logic                         hp;
  logic [7:0]                   pk;
  logic [7:0]                   h;
  logic                         cons;
  logic                         do_start;
  logic                         do_real;
  logic                         uc;
  bundle_t                      b;

  // Scan the held character against its lookahead and build the token group
  always_comb begin
    hpos = POSITION_WIDTH'(pos_q - 1'b1);
    hp = !kind_i;
    pk = kind_i ? 8'd0 : ch_i;
    h = held_q;
    mode_d = mode_q;
    dec_d = dec_q;
    line_d = line_q;
    tbeg_d = tbeg_q;
    tcnt_d = tcnt_q;
    kb_d = kb_q;
    b = '0;
    cons = 1'b0;
    do_start = 1'b0;
    do_real = 1'b0;
    uc = 1'b0;

    if (hvalid_q) begin
      unique case (mode_d)
        M_ID: begin
          if (is_alpha(h) || is_digit(h) || h == "_") begin
            if (tcnt_d < LEN_W'(KW_BUF)) begin
              kb_d[tcnt_d[2:0]] = upcase(h);
            end
            tcnt_d = sat_inc(tcnt_d);
          end else begin
            b = put(b, kw_lookup(kb_d, tcnt_d), LINE_OUT_W'(line_d), START_W'(tbeg_d),
                    tcnt_d, 1'b0);
            mode_d = M_START;
            dec_d = 1'b0;
            do_start = 1'b1;
          end
        end
        M_STR: begin
          if (h == "\n") begin
            b = put(b, TOK_ERR, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            mode_d = M_START;
            dec_d = 1'b0;
          end else if (h == "'") begin
            b = put(b, TOK_SCONST, LINE_OUT_W'(line_d),
                    START_W'(POSITION_WIDTH'(tbeg_d + 1'b1)), LEN_W'(tcnt_d - 1'b1), 1'b0);
            mode_d = M_START;
          end else begin
            tcnt_d = sat_inc(tcnt_d);
          end
        end
        M_INT: begin
          if (is_digit(h)) begin
            tcnt_d = sat_inc(tcnt_d);
          end else if (h == ".") begin
            mode_d = M_REAL;
            dec_d = 1'b0;
            do_real = 1'b1;
          end else begin
            b = put(b, TOK_ICONST, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            mode_d = M_START;
            dec_d = 1'b0;
            do_start = 1'b1;
          end
        end
        M_REAL: begin
          do_real = 1'b1;
        end
        M_COMMENT: begin
          if (h == "\n") begin
            line_d = LINE_WIDTH'(line_d + 1'b1);
          end else if (h == "*" && hp && pk == ")") begin
            mode_d = M_START;
            cons = 1'b1;
          end
        end
        default: begin
          mode_d = M_START;
          do_start = 1'b1;
        end
      endcase

      // Real constant: decimal point and fraction digits
      if (do_real) begin
        if (h == "." && !dec_d) begin
          tcnt_d = sat_inc(tcnt_d);
          if (hp && is_digit(pk)) begin
            dec_d = 1'b1;
          end else begin
            b = put(b, TOK_ERR, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            mode_d = M_START;
            dec_d = 1'b0;
          end
        end else if (is_digit(h) && dec_d) begin
          tcnt_d = sat_inc(tcnt_d);
        end else if (h == ".") begin
          tcnt_d = sat_inc(tcnt_d);
          b = put(b, TOK_ERR, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
          mode_d = M_START;
          dec_d = 1'b0;
        end else begin
          b = put(b, TOK_RCONST, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
          mode_d = M_START;
          dec_d = 1'b0;
          do_start = 1'b1;
        end
      end

      // Start a new token on this character
      if (do_start) begin
        if (h == "\n") begin
          line_d = LINE_WIDTH'(line_d + 1'b1);
        end
        if (!is_space(h)) begin
          tbeg_d = hpos;
          tcnt_d = LEN_W'(1);
          dec_d = 1'b0;
          if (is_alpha(h) || h == "_") begin
            kb_d[0] = upcase(h);
            mode_d = M_ID;
          end else if (h == "'") begin
            mode_d = M_STR;
          end else if (is_digit(h)) begin
            mode_d = M_INT;
          end else if (h == "(") begin
            if (hp && pk == "*") begin
              mode_d = M_COMMENT;
              cons = 1'b1;
            end else begin
              b = put(b, TOK_LPAREN, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            end
          end else if (h == ":") begin
            if (hp && pk == "=") begin
              tcnt_d = LEN_W'(2);
              b = put(b, TOK_ASSOP, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
              cons = 1'b1;
            end else begin
              b = put(b, TOK_COLON, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            end
          end else if (h == ".") begin
            if (hp && is_digit(pk)) begin
              mode_d = M_REAL;
              dec_d = 1'b1;
            end else begin
              tcnt_d = hp ? LEN_W'(2) : LEN_W'(1);
              b = put(b, TOK_ERR, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
            end
          end else begin
            b = put(b, sym_token(h), LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
          end
        end
      end
    end

    if (kind_i) begin
      // End of input: flush the pending token, then report done
      unique case (mode_d)
        M_ID: b = put(b, kw_lookup(kb_d, tcnt_d), LINE_OUT_W'(line_d), START_W'(tbeg_d),
                      tcnt_d, 1'b0);
        M_STR: b = put(b, TOK_ERR, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
        M_INT: b = put(b, TOK_ICONST, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
        M_REAL: b = put(b, TOK_RCONST, LINE_OUT_W'(line_d), START_W'(tbeg_d), tcnt_d, 1'b0);
        M_COMMENT: uc = 1'b1;
        default: uc = 1'b0;
      endcase
      b = put(b, TOK_DONE, LINE_OUT_W'(line_d), '0, '0, uc);
      mode_d = M_START;
      dec_d = 1'b0;
      held_d = 8'd0;
      hvalid_d = 1'b0;
      line_d = LINE_WIDTH'(start_line_q);
      pos_d = '0;
      tbeg_d = '0;
      tcnt_d = '0;
    end else begin
      held_d = cons ? 8'd0 : ch_i;
      hvalid_d = !cons;
      pos_d = POSITION_WIDTH'(pos_q + 1'b1);
    end
  end

  assign bundle_o = b;
  assign bundle_valid_o = (b.n != '0);

  // Advance scan state on each accepted transaction; load line on config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START;
      dec_q <= 1'b0;
      held_q <= 8'd0;
      hvalid_q <= 1'b0;
      line_q <= LINE_WIDTH'(1);
      start_line_q <= LINE_OUT_W'(1);
      pos_q <= '0;
      tbeg_q <= '0;
      tcnt_q <= '0;
    end else if (cfg_we_i) begin
      start_line_q <= cfg_wdata_i;
      line_q <= LINE_WIDTH'(cfg_wdata_i);
    end else if (accept_i) begin
      mode_q <= mode_d;
      dec_q <= dec_d;
      held_q <= held_d;
      hvalid_q <= hvalid_d;
      line_q <= line_d;
      pos_q <= pos_d;
      tbeg_q <= tbeg_d;
      tcnt_q <= tcnt_d;
    end
  end

  // Keyword buffer holds identifier bytes only
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      kb_q <= kb_d;
    end
  end

endmodule

`default_nettype wire

[sv/pstsc_back.sv]
// ----------------------------------------------------------------------------
// pstsc_back: token group queue and result serializer
// Queues token groups from the scanner and hands them out one token per
// transaction, marking the last token of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module pstsc_back
  import pstsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  bundle_t   wr_data_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output tok_t      tok_o,
  output logic      last_o
);

  bundle_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   rd_q, wr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic [NRES_W-1:0]   sel_q, sel_d;
  logic                push_en;
  logic                pop_en;
  logic                pop_group;

  assign full_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_en = wr_en_i && !full_o;
  assign pop_en = pop_i && !empty_o;

  assign tok_o = mem_q[rd_q].toks[sel_q];
  assign last_o = (sel_q == NRES_W'(mem_q[rd_q].n - 1'b1));
  assign pop_group = pop_en && last_o;

  // Step through the tokens of the oldest group
  always_comb begin
    sel_d = sel_q;
    if (pop_en) begin
      sel_d = last_o ? '0 : NRES_W'(sel_q + 1'b1);
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
      if (push_en) begin
        wr_q <= QPTR_W'(wr_q + 1'b1);
      end
      if (pop_group) begin
        rd_q <= QPTR_W'(rd_q + 1'b1);
      end
      cnt_q <= QCNT_W'(cnt_q + QCNT_W'(push_en) - QCNT_W'(pop_group));
    end
  end

  // Store incoming groups
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/pascal_subset_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// pascal_subset_token_scanner_unit: token scanner for a small Pascal subset
// Scans source bytes into keyword, identifier, constant and symbol tokens.
// ----------------------------------------------------------------------------
// The scanner takes one source character per cycle while full_o is low and
// turns it into a group of zero to three tokens in the same cycle; groups wait
// in a two-entry queue and leave through the result port at one token per
// cycle while pop_i is high. A character's k tokens need k pops, and input
// stalls (full_o) only when the queue has two groups waiting. Each character
// is held back one transaction as lookahead, so a token appears when the
// character after it arrives; end of input flushes any pending token and
// then gives DONE. start_line may be written only while the block is idle.
`default_nettype none

module pascal_subset_token_scanner_unit
  import pstsc_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [LINE_OUT_W-1:0] cfg_wdata_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic [TOKEN_W-1:0]         token_o,
  output logic [LINE_OUT_W-1:0]      line_o,
  output logic [START_W-1:0]         lexeme_start_o,
  output logic [LEN_W-1:0]           lexeme_length_o,
  output logic                       unclosed_comment_o,
  output logic                       last_o
);

  logic    accept;
  bundle_t bundle;
  logic    bundle_valid;
  tok_t    tok;

  assign accept = push_i && !full_o;

  pstsc_front #(
    .LINE_WIDTH(LINE_WIDTH),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .accept_i(accept),
    .kind_i(kind_i),
    .ch_i(ch_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .bundle_o(bundle),
    .bundle_valid_o(bundle_valid)
  );

  pstsc_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .wr_en_i(accept && bundle_valid),
    .wr_data_i(bundle),
    .full_o(full_o),
    .empty_o(empty_o),
    .pop_i(pop_i),
    .tok_o(tok),
    .last_o(last_o)
  );

  assign token_o = tok.token;
  assign line_o = tok.line;
  assign lexeme_start_o = tok.lexeme_start;
  assign lexeme_length_o = tok.lexeme_length;
  assign unclosed_comment_o = tok.unclosed_comment;

`ifndef SYNTH
  // DONE closes the group of its transaction
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && token_o == TOK_DONE) |-> last_o)
    else $error("DONE token not marked last");

  // DONE carries an empty lexeme
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && token_o == TOK_DONE) |-> (lexeme_start_o == '0 && lexeme_length_o == '0))
    else $error("DONE token with nonempty lexeme");

  // Unclosed comment flag appears only on DONE
  a_uc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && unclosed_comment_o) |-> token_o == TOK_DONE)
    else $error("unclosed comment flag on non-DONE token");
`endif

endmodule

`default_nettype wire

[dv/pascal_subset_token_scanner_unit_tb.sv]
// ----------------------------------------------------------------------------
// pascal_subset_token_scanner_unit_tb: self-checking bench of the token scanner
// Feeds character streams (directed, then random Pascal-like text with noise)
// through the push/full port under several start_line settings, predicts each
// token group and checks every popped token field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pascal_subset_token_scanner_unit_tb;
  import pstsc_pkg::*;

  typedef struct {
    logic       kind;
    logic [7:0] ch;
  } src_item_t;

  typedef struct {
    logic [TOKEN_W-1:0]    token;
    logic [LINE_OUT_W-1:0] line;
    logic [START_W-1:0]    lexeme_start;
    logic [LEN_W-1:0]      lexeme_length;
    logic                  unclosed_comment;
    logic                  last;
  } token_rec_t;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push_i = 1'b0;
  logic                  full_o;
  logic                  kind_i = 1'b0;
  logic [7:0]            ch_i = 8'd0;
  logic                  cfg_we_i = 1'b0;
  logic [LINE_OUT_W-1:0] cfg_wdata_i = '0;
  logic                  empty_o;
  logic                  pop_i = 1'b0;
  logic [TOKEN_W-1:0]    token_o;
  logic [LINE_OUT_W-1:0] line_o;
  logic [START_W-1:0]    lexeme_start_o;
  logic [LEN_W-1:0]      lexeme_length_o;
  logic                  unclosed_comment_o;
  logic                  last_o;

  pascal_subset_token_scanner_unit i_dut (
    .clk_i, .rst_ni, .push_i, .full_o, .kind_i, .ch_i, .cfg_we_i, .cfg_wdata_i,
    .empty_o, .pop_i, .token_o, .line_o, .lexeme_start_o, .lexeme_length_o,
    .unclosed_comment_o, .last_o
  );

  src_item_t  pending_chars[$];
  token_rec_t expected_tokens[$];
  token_rec_t group_tokens[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;

  // Scanner shadow state
  mode_e                 sc_mode;
  logic                  frac_seen;
  logic [7:0]            held_ch;
  logic                  held_ok;
  logic [LINE_OUT_W-1:0] start_line_reg;
  logic [LINE_OUT_W-1:0] line_cnt;
  logic [START_W-1:0]    pos_cnt;
  logic [START_W-1:0]    tok_begin;
  logic [LEN_W-1:0]      tok_len;
  logic [7:0]            kw_buf[KW_BUF];

  string kw_words[15] = '{"PROGRAM", "WRITELN", "INTEGER", "END", "REAL", "STRING",
                          "FOR", "VAR", "ELSE", "IF", "BEGIN", "THEN", "DO", "TO",
                          "DOWNTO"};

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void clear_scan();
    sc_mode = M_START;
    frac_seen = 1'b0;
    held_ch = 8'd0;
    held_ok = 1'b0;
    line_cnt = start_line_reg;
    pos_cnt = '0;
    tok_begin = '0;
    tok_len = '0;
    for (int i = 0; i < KW_BUF; i++) kw_buf[i] = 8'd0;
  endfunction

  function automatic void grow_len();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic void add_token(logic [TOKEN_W-1:0] tok, logic [START_W-1:0] st,
                                    logic [LEN_W-1:0] len, logic uc);
    token_rec_t r;
    r.token = tok;
    r.line = line_cnt;
    r.lexeme_start = st;
    r.lexeme_length = len;
    r.unclosed_comment = uc;
    r.last = 1'b0;
    if (group_tokens.size() < NRES) group_tokens.push_back(r);
  endfunction

  function automatic void close_token(logic [TOKEN_W-1:0] tok);
    add_token(tok, tok_begin, tok_len, 1'b0);
    sc_mode = M_START;
    frac_seen = 1'b0;
  endfunction

  // Identifier or keyword, first table hit wins
  function automatic void close_ident();
    logic [TOKEN_W-1:0] tok;
    bit                 hit;
    tok = TOK_IDENT;
    for (int k = KW_N - 1; k >= 0; k--) begin
      hit = (tok_len == LEN_W'(kw_words[k].len()));
      for (int i = 0; i < kw_words[k].len() && i < KW_BUF; i++)
        if (kw_buf[i] != kw_words[k][i]) hit = 0;
      if (hit) tok = TOKEN_W'(k);
    end
    close_token(tok);
  endfunction

  function automatic bit scan_start(logic [7:0] h, logic [START_W-1:0] hpos, bit hp,
                                    logic [7:0] pk);
    logic [TOKEN_W-1:0] t;
    if (h == 8'h0A) line_cnt++;
    if (h == " " || (h >= 8'd9 && h <= 8'd13)) return 0;
    tok_begin = hpos;
    tok_len = 16'd1;
    frac_seen = 1'b0;
    if (is_alpha(h) || h == "_") begin
      kw_buf[0] = to_upper(h);
      sc_mode = M_ID;
    end else if (h == "'") begin
      sc_mode = M_STR;
    end else if (is_digit(h)) begin
      sc_mode = M_INT;
    end else if (h == "(") begin
      if (hp && pk == "*") begin
        sc_mode = M_COMMENT;
        return 1;
      end
      close_token(TOK_LPAREN);
    end else if (h == ":") begin
      if (hp && pk == "=") begin
        tok_len = 16'd2;
        close_token(TOK_ASSOP);
        return 1;
      end
      close_token(TOK_COLON);
    end else if (h == ".") begin
      if (hp && is_digit(pk)) begin
        sc_mode = M_REAL;
        frac_seen = 1'b1;
      end else begin
        tok_len = hp ? 16'd2 : 16'd1;
        close_token(TOK_ERR);
      end
    end else begin
      case (h)
        "+": t = TOK_PLUS;
        "-": t = TOK_MINUS;
        "*": t = TOK_MULT;
        "/": t = TOK_DIV;
        "=": t = TOK_EQUAL;
        ">": t = TOK_GTHAN;
        "<": t = TOK_LTHAN;
        ",": t = TOK_COMMA;
        ")": t = TOK_RPAREN;
        ";": t = TOK_SEMICOL;
        default: t = TOK_ERR;
      endcase
      close_token(t);
    end
    return 0;
  endfunction

  function automatic bit scan_real(logic [7:0] h, logic [START_W-1:0] hpos, bit hp,
                                   logic [7:0] pk);
    if (h == "." && !frac_seen) begin
      grow_len();
      if (hp && is_digit(pk)) frac_seen = 1'b1;
      else close_token(TOK_ERR);
    end else if (is_digit(h) && frac_seen) begin
      grow_len();
    end else if (h == ".") begin
      grow_len();
      close_token(TOK_ERR);
    end else begin
      close_token(TOK_RCONST);
      return scan_start(h, hpos, hp, pk);
    end
    return 0;
  endfunction

  // Scan the held character; return 1 when the lookahead is consumed too
  function automatic bit scan_held(logic [7:0] h, logic [START_W-1:0] hpos, bit hp,
                                   logic [7:0] pk);
    case (sc_mode)
      M_ID: begin
        if (is_alpha(h) || is_digit(h) || h == "_") begin
          if (tok_len < LEN_W'(KW_BUF)) kw_buf[tok_len[2:0]] = to_upper(h);
          grow_len();
          return 0;
        end
        close_ident();
        return scan_start(h, hpos, hp, pk);
      end
      M_STR: begin
        if (h == 8'h0A) begin
          close_token(TOK_ERR);
        end else if (h == "'") begin
          add_token(TOK_SCONST, START_W'(tok_begin + 1'b1), LEN_W'(tok_len - 1'b1), 1'b0);
          sc_mode = M_START;
        end else begin
          grow_len();
        end
        return 0;
      end
      M_INT: begin
        if (is_digit(h)) begin
          grow_len();
          return 0;
        end
        if (h == ".") begin
          sc_mode = M_REAL;
          frac_seen = 1'b0;
          return scan_real(h, hpos, hp, pk);
        end
        close_token(TOK_ICONST);
        return scan_start(h, hpos, hp, pk);
      end
      M_REAL: return scan_real(h, hpos, hp, pk);
      M_COMMENT: begin
        if (h == 8'h0A) line_cnt++;
        else if (h == "*" && hp && pk == ")") begin
          sc_mode = M_START;
          return 1;
        end
        return 0;
      end
      default: begin
        sc_mode = M_START;
        return scan_start(h, hpos, hp, pk);
      end
    endcase
  endfunction

  // Predict the token group of one accepted transaction
  function automatic void predict_tokens(logic kind, logic [7:0] c);
    logic [START_W-1:0] hpos;
    bit                 used;
    logic               uc;
    hpos = START_W'(pos_cnt - 1'b1);
    group_tokens.delete();
    if (!kind) begin
      used = 0;
      if (held_ok) used = scan_held(held_ch, hpos, 1, c);
      if (used) begin
        held_ok = 1'b0;
        held_ch = 8'd0;
      end else begin
        held_ch = c;
        held_ok = 1'b1;
      end
      pos_cnt++;
    end else begin
      uc = 1'b0;
      if (held_ok) void'(scan_held(held_ch, hpos, 0, 8'd0));
      case (sc_mode)
        M_ID: close_ident();
        M_STR: close_token(TOK_ERR);
        M_INT: close_token(TOK_ICONST);
        M_REAL: close_token(TOK_RCONST);
        M_COMMENT: uc = 1'b1;
        default: ;
      endcase
      add_token(TOK_DONE, '0, '0, uc);
      clear_scan();
    end
    if (group_tokens.size() > 0) group_tokens[group_tokens.size()-1].last = 1'b1;
    foreach (group_tokens[i]) expected_tokens.push_back(group_tokens[i]);
  endfunction

  // Stimulus helpers
  task automatic add_text(string s);
    src_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.kind = 1'b0;
      it.ch = s[i];
      pending_chars.push_back(it);
    end
  endtask

  task automatic add_byte(logic [7:0] b, logic kind = 1'b0);
    src_item_t it;
    it.kind = kind;
    it.ch = b;
    pending_chars.push_back(it);
  endtask

  task automatic add_digits(int unsigned n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range("0", "9")));
  endtask

  // One random lexical fragment, mostly well formed
  task automatic add_fragment();
    string w;
    case ($urandom_range(0, 13))
      0, 1: begin
        w = kw_words[$urandom_range(0, 14)];
        for (int i = 0; i < w.len(); i++)
          add_byte($urandom_range(0, 1) ? w[i] + 8'd32 : w[i]);
      end
      2: begin
        add_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : "_");
        repeat ($urandom_range(0, 9)) add_byte(8'($urandom_range("A", "Z")));
      end
      3: add_digits($urandom_range(1, 4));
      4: begin
        add_digits($urandom_range(0, 2));
        add_byte(".");
        add_digits($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) add_byte(".");
      end
      5: begin
        add_byte("'");
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(" ", "&")));
        case ($urandom_range(0, 5))
          0: add_byte(8'h0A);
          1: ;
          default: add_byte("'");
        endcase
      end
      6: begin
        add_text("(*");
        repeat ($urandom_range(0, 4))
          add_byte($urandom_range(0, 2) == 0 ? 8'h0A : 8'($urandom_range("a", "z")));
        if ($urandom_range(0, 4) != 0) add_text("*)");
      end
      7, 8: begin
        w = "+-*/=><,();:.";
        add_byte(w[$urandom_range(0, w.len() - 1)]);
        if ($urandom_range(0, 2) == 0) add_byte("=");
      end
      9, 10: add_byte(" ");
      11: add_byte($urandom_range(0, 1) ? 8'h0A : 8'($urandom_range(9, 13)));
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic write_start_line(logic [LINE_OUT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    start_line_reg = v;
    line_cnt = v;
  endtask

  // Hold until every transaction has gone through, then let the queue settle
  task automatic drain();
    while (pending_chars.size() != 0 || expected_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drive source characters, with random idle bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else if (push_gap > 0) begin
      push_gap <= push_gap - 1;
      push_i <= 1'b0;
    end else if (pending_chars.size() == 0) begin
      push_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      push_gap <= $urandom_range(0, 3);
      push_i <= 1'b0;
    end else begin
      push_i <= 1'b1;
      kind_i <= pending_chars[0].kind;
      ch_i <= pending_chars[0].ch;
    end
  end

  // Drive pop, with random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      pop_gap <= $urandom_range(0, 3);
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // Predict on accepted input, check on accepted tokens
  always @(posedge clk_i) begin
    token_rec_t exp_tok;
    if (rst_ni && push_i && !full_o) begin
      predict_tokens(kind_i, ch_i);
      void'(pending_chars.pop_front());
    end
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token %0d", token_o);
        fail_count++;
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (token_o !== exp_tok.token) begin
          $error("token expected %0d got %0d", exp_tok.token, token_o);
          fail_count++;
        end
        if (line_o !== exp_tok.line) begin
          $error("line expected %0d got %0d", exp_tok.line, line_o);
          fail_count++;
        end
        if (lexeme_start_o !== exp_tok.lexeme_start) begin
          $error("lexeme_start expected %0d got %0d", exp_tok.lexeme_start,
                 lexeme_start_o);
          fail_count++;
        end
        if (lexeme_length_o !== exp_tok.lexeme_length) begin
          $error("lexeme_length expected %0d got %0d", exp_tok.lexeme_length,
                 lexeme_length_o);
          fail_count++;
        end
        if (unclosed_comment_o !== exp_tok.unclosed_comment) begin
          $error("unclosed_comment expected %0d got %0d", exp_tok.unclosed_comment,
                 unclosed_comment_o);
          fail_count++;
        end
        if (last_o !== exp_tok.last) begin
          $error("last expected %0d got %0d", exp_tok.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Sequence of phases
  initial begin
    logic [LINE_OUT_W-1:0] line_setting[4];
    int unsigned           budget;
    start_line_reg = 16'd1;
    clear_scan();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: keywords, symbols, dot errors, string newline, long ident
    add_text("program Wr1te_ := 3.5..7.x");
    add_byte(8'h0A);
    add_text("'a");
    add_byte(8'h0A);
    add_text("(*z*)downto_long_name 'q' 9.");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h7F, 1'b1);
    drain();

    // Directed under the largest setting: wrap, unclosed comment, open string
    write_start_line(16'hFFFF);
    add_text("end;");
    add_byte(8'h0A);
    add_text("x (*");
    add_byte(8'h0A);
    add_byte(8'h00, 1'b1);
    add_text("'abc");
    add_byte(8'h00, 1'b1);
    add_text(".");
    add_byte(8'h00, 1'b1);
    drain();

    // Random text over several start_line settings
    line_setting = '{16'd0, 16'hFFFE, 16'($urandom()), 16'd1};
    foreach (line_setting[p]) begin
      write_start_line(line_setting[p]);
      if (p == 3) quiet = 1'b1;
      budget = pending_chars.size() + 40;
      while (pending_chars.size() < budget) begin
        repeat ($urandom_range(3, 12)) add_fragment();
        add_byte(8'($urandom()), 1'b1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/pstsc_pkg.sv
sv/pstsc_front.sv
sv/pstsc_back.sv
sv/pascal_subset_token_scanner_unit.sv
dv/pascal_subset_token_scanner_unit_tb.sv
